### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/tqlru_pkg.sv
package tqlru_pkg;

   localparam int HOT_DEPTH_DEF  = 16;
   localparam int COLD_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF   = 16;

   localparam int CAP_BITS = 5;
   localparam int CNT_BITS = 6;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      Q_HOLD,
      Q_PUSH,
      Q_MOVE_FRONT,
      Q_REMOVE,
      Q_DROP_TAIL,
      Q_ROTATE
   } qop_type;

   typedef enum logic [1:0] {
      CS_HOLD,
      CS_LEFT,
      CS_RIGHT,
      CS_WRAP
   } cell_src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRIM,
      ST_DUMP_HOT,
      ST_DUMP_COLD
   } state_type;

   typedef enum logic {
      FUNC_ACCESS = 1'b0,
      FUNC_DUMP   = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACCESS = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FOUND_NONE = 2'd0,
      FOUND_HOT  = 2'd1,
      FOUND_COLD = 2'd2
   } found_type;

   typedef enum logic {
      CSR_HOT_CAP  = 1'b0,
      CSR_COLD_CAP = 1'b1
   } csr_index_type;

   typedef enum logic {
      QUEUE_HOT  = 1'b0,
      QUEUE_COLD = 1'b1
   } queue_id_type;

   typedef struct packed {
      logic                hit;
      logic [CNT_BITS-1:0] count;
   } qstat_type;

endpackage

### design/tqlru_cell.sv
module tqlru_cell
   import tqlru_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic                clock,
   input  cell_src_type        src,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [KEY_BITS-1:0] wrap_key,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  logic                valid,
   output logic [KEY_BITS-1:0] key,
   output logic                match
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;

   always_comb begin
      case (src)
         CS_LEFT:  key_in = left_key;
         CS_RIGHT: key_in = right_key;
         CS_WRAP:  key_in = wrap_key;
         default:  key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign match = valid && (key_ff == cmp_key);

endmodule

### design/tqlru_queue.sv
module tqlru_queue
   import tqlru_pkg::*;
#(
   parameter int DEPTH    = HOT_DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  qop_type             op,
   input  logic [KEY_BITS-1:0] in_key,
   output logic [KEY_BITS-1:0] head_key,
   output logic [KEY_BITS-1:0] tail_key,
   output qstat_type           stat
);

`include "assert_macros.svh"

   localparam int N = DEPTH + 1;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [N-1:0]        match_vec;
   logic [N-1:0]        valid_vec;
   logic [N-1:0]        tail_vec;
   logic [N-1:0]        upto_vec;
   logic [N-1:0]        from_vec;
   logic [KEY_BITS-1:0] cell_key [N];
   cell_src_type        src      [N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [KEY_BITS-1:0] left_key;
      logic [KEY_BITS-1:0] right_key;

      assign valid_vec[i] = CNT_BITS'(i) < count_ff;
      assign tail_vec[i]  = CNT_BITS'(i + 1) == count_ff;
      assign upto_vec[i]  = |match_vec[i:0];
      assign from_vec[i]  = |match_vec[N-1:i];

      if (i == 0) begin : g_first
         assign left_key = in_key;
      end else begin : g_inner
         assign left_key = cell_key[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_key = '0;
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      always_comb begin
         case (op)
            Q_PUSH:       src[i] = CS_LEFT;
            Q_MOVE_FRONT: src[i] = from_vec[i] ? CS_LEFT : CS_HOLD;
            Q_REMOVE:     src[i] = upto_vec[i] ? CS_RIGHT : CS_HOLD;
            Q_ROTATE:     src[i] = tail_vec[i] ? CS_WRAP : CS_RIGHT;
            default:      src[i] = CS_HOLD;
         endcase
      end

      tqlru_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .src       (src[i]),
         .left_key  (left_key),
         .right_key (right_key),
         .wrap_key  (cell_key[0]),
         .cmp_key   (in_key),
         .valid     (valid_vec[i]),
         .key       (cell_key[i]),
         .match     (match_vec[i])
      );
   end

   always_comb begin
      tail_key = '0;
      for (int i = 0; i < N; i++) begin
         tail_key = tail_key | ({KEY_BITS{tail_vec[i]}} & cell_key[i]);
      end
   end

   always_comb begin
      case (op)
         Q_PUSH:      count_in = count_ff + 1'b1;
         Q_REMOVE:    count_in = count_ff - 1'b1;
         Q_DROP_TAIL: count_in = count_ff - 1'b1;
         default:     count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_key   = cell_key[0];
   assign stat.hit   = |match_vec;
   assign stat.count = count_ff;

   `ASSERT_CLK(a_key_unique, $onehot0(match_vec), "key held in more than one cell")
   `ASSERT_CLK(a_remove_hit, (op == Q_REMOVE) |-> (|match_vec), "remove without a hit")
   `ASSERT_CLK(a_no_underflow, (op == Q_DROP_TAIL || op == Q_ROTATE) |-> (count_ff != '0),
      "tail operation on an empty queue")

endmodule

### design/two_queue_lru_tracker.sv
// Access: start taken while busy is low; report strobed on rsp_valid from the register
// loaded in ST_TRIM. Accesses do not overlap: the accepting cycle searches and shifts the
// cell rows, and ST_TRIM trims the overflowing tail and registers the report.
// Dump: one entry per cycle (hot then cold, a row rotation per entry), each registered from its
// dump state; a dump of empty queues reports in the next cycle. Results cannot be stalled.
// Synchronous reset empties both queues and sets both capacities to 16.
module two_queue_lru_tracker
   import tqlru_pkg::*;
#(
   parameter int HOT_DEPTH  = HOT_DEPTH_DEF,
   parameter int COLD_DEPTH = COLD_DEPTH_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   output logic [1:0]          rsp_reply_kind,
   output logic [1:0]          rsp_found_in,
   output logic                rsp_demoted_valid,
   output logic [KEY_BITS-1:0] rsp_demoted_key,
   output logic                rsp_dropped_valid,
   output logic [KEY_BITS-1:0] rsp_dropped_key,
   output logic                rsp_entry_queue,
   output logic [KEY_BITS-1:0] rsp_entry_key,
   output logic                rsp_is_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CAP_BITS-1:0] csr_wdata
);

`include "assert_macros.svh"

   state_type           state_ff, state_in;
   found_type           found_ff, found_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in, idx_next;
   logic [CAP_BITS-1:0] hot_cap_ff, hot_cap_in;
   logic [CAP_BITS-1:0] cold_cap_ff, cold_cap_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [1:0]          rsp_fnd_ff, rsp_fnd_in;
   logic                rsp_dv_ff, rsp_dv_in;
   logic [KEY_BITS-1:0] rsp_dk_ff, rsp_dk_in;
   logic                rsp_xv_ff, rsp_xv_in;
   logic [KEY_BITS-1:0] rsp_xk_ff, rsp_xk_in;
   logic                rsp_eq_ff, rsp_eq_in;
   logic [KEY_BITS-1:0] rsp_ek_ff, rsp_ek_in;
   logic                rsp_last_ff, rsp_last_in;

   qop_type             hot_op, cold_op;
   logic [KEY_BITS-1:0] cold_in_key;
   logic [KEY_BITS-1:0] hot_head, hot_tail, cold_head, cold_tail;
   qstat_type           hot_stat, cold_stat;
   logic [CNT_BITS-1:0] hot_lim, cold_lim;
   logic                accept;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign idx_next  = idx_ff + 1'b1;

   assign hot_lim  = (CNT_BITS'(hot_cap_ff) > CNT_BITS'(HOT_DEPTH)) ?
                     CNT_BITS'(HOT_DEPTH) : CNT_BITS'(hot_cap_ff);
   assign cold_lim = (CNT_BITS'(cold_cap_ff) > CNT_BITS'(COLD_DEPTH)) ?
                     CNT_BITS'(COLD_DEPTH) : CNT_BITS'(cold_cap_ff);

   assign cold_in_key = (state_ff == ST_TRIM) ? hot_tail : req_key;

   tqlru_queue #(
      .DEPTH    (HOT_DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_hot (
      .clock    (clock),
      .reset    (reset),
      .op       (hot_op),
      .in_key   (req_key),
      .head_key (hot_head),
      .tail_key (hot_tail),
      .stat     (hot_stat)
   );

   tqlru_queue #(
      .DEPTH    (COLD_DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_cold (
      .clock    (clock),
      .reset    (reset),
      .op       (cold_op),
      .in_key   (cold_in_key),
      .head_key (cold_head),
      .tail_key (cold_tail),
      .stat     (cold_stat)
   );

   always_comb begin
      hot_cap_in  = hot_cap_ff;
      cold_cap_in = cold_cap_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOT_CAP:  hot_cap_in  = csr_wdata;
            CSR_COLD_CAP: cold_cap_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      hot_op       = Q_HOLD;
      cold_op      = Q_HOLD;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_fnd_in   = rsp_fnd_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_dk_in    = rsp_dk_ff;
      rsp_xv_in    = rsp_xv_ff;
      rsp_xk_in    = rsp_xk_ff;
      rsp_eq_in    = rsp_eq_ff;
      rsp_ek_in    = rsp_ek_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_func == FUNC_DUMP) begin
                  if (hot_stat.count == '0 && cold_stat.count == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_EMPTY;
                     rsp_fnd_in   = FOUND_NONE;
                     rsp_dv_in    = 1'b0;
                     rsp_dk_in    = '0;
                     rsp_xv_in    = 1'b0;
                     rsp_xk_in    = '0;
                     rsp_eq_in    = QUEUE_HOT;
                     rsp_ek_in    = '0;
                     rsp_last_in  = 1'b1;
                  end else if (hot_stat.count != '0) begin
                     state_in = ST_DUMP_HOT;
                  end else begin
                     state_in = ST_DUMP_COLD;
                  end
               end else begin
                  state_in = ST_TRIM;
                  if (hot_stat.hit) begin
                     hot_op   = Q_MOVE_FRONT;
                     found_in = FOUND_HOT;
                  end else if (cold_stat.hit) begin
                     cold_op  = Q_REMOVE;
                     hot_op   = Q_PUSH;
                     found_in = FOUND_COLD;
                  end else begin
                     cold_op  = Q_PUSH;
                     found_in = FOUND_NONE;
                  end
               end
            end
         end
         ST_TRIM: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ACCESS;
            rsp_fnd_in   = found_ff;
            rsp_dv_in    = 1'b0;
            rsp_dk_in    = '0;
            rsp_xv_in    = 1'b0;
            rsp_xk_in    = '0;
            rsp_eq_in    = QUEUE_HOT;
            rsp_ek_in    = '0;
            rsp_last_in  = 1'b1;
            if (found_ff != FOUND_NONE) begin
               if (hot_stat.count > hot_lim) begin
                  hot_op = Q_DROP_TAIL;
                  if (cold_stat.count < cold_lim) begin
                     cold_op   = Q_PUSH;
                     rsp_dv_in = 1'b1;
                     rsp_dk_in = hot_tail;
                  end else begin
                     rsp_xv_in = 1'b1;
                     rsp_xk_in = hot_tail;
                  end
               end
            end else if (cold_stat.count > cold_lim) begin
               cold_op   = Q_DROP_TAIL;
               rsp_xv_in = 1'b1;
               rsp_xk_in = cold_tail;
            end
         end
         ST_DUMP_HOT: begin
            hot_op       = Q_ROTATE;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ENTRY;
            rsp_fnd_in   = FOUND_NONE;
            rsp_dv_in    = 1'b0;
            rsp_dk_in    = '0;
            rsp_xv_in    = 1'b0;
            rsp_xk_in    = '0;
            rsp_eq_in    = QUEUE_HOT;
            rsp_ek_in    = hot_head;
            rsp_last_in  = (idx_next == hot_stat.count) && (cold_stat.count == '0);
            if (idx_next == hot_stat.count) begin
               idx_in   = '0;
               state_in = (cold_stat.count != '0) ? ST_DUMP_COLD : ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_DUMP_COLD: begin
            cold_op      = Q_ROTATE;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ENTRY;
            rsp_fnd_in   = FOUND_NONE;
            rsp_dv_in    = 1'b0;
            rsp_dk_in    = '0;
            rsp_xv_in    = 1'b0;
            rsp_xk_in    = '0;
            rsp_eq_in    = QUEUE_COLD;
            rsp_ek_in    = cold_head;
            rsp_last_in  = idx_next == cold_stat.count;
            if (idx_next == cold_stat.count) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= FOUND_NONE;
         idx_ff       <= '0;
         hot_cap_ff   <= CAP_RESET;
         cold_cap_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         hot_cap_ff   <= hot_cap_in;
         cold_cap_ff  <= cold_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_fnd_ff   <= rsp_fnd_in;
      rsp_dv_ff    <= rsp_dv_in;
      rsp_dk_ff    <= rsp_dk_in;
      rsp_xv_ff    <= rsp_xv_in;
      rsp_xk_ff    <= rsp_xk_in;
      rsp_eq_ff    <= rsp_eq_in;
      rsp_ek_ff    <= rsp_ek_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_kind    = rsp_kind_ff;
   assign rsp_found_in      = rsp_fnd_ff;
   assign rsp_demoted_valid = rsp_dv_ff;
   assign rsp_demoted_key   = rsp_dk_ff;
   assign rsp_dropped_valid = rsp_xv_ff;
   assign rsp_dropped_key   = rsp_xk_ff;
   assign rsp_entry_queue   = rsp_eq_ff;
   assign rsp_entry_key     = rsp_ek_ff;
   assign rsp_is_last       = rsp_last_ff;

   `ASSERT_CLK(a_access_report, (start && !busy && req_func == FUNC_ACCESS) |=> ##1 rsp_valid,
      "access transaction without a report")
   `ASSERT_CLK(a_empty_dump, (start && !busy && req_func == FUNC_DUMP &&
      hot_stat.count == '0 && cold_stat.count == '0) |=> (rsp_valid && rsp_is_last &&
      rsp_reply_kind == KIND_EMPTY), "empty dump not reported")
   `ASSERT_CLK(a_idle_counts, (state_ff == ST_IDLE) |-> (hot_stat.count <= CNT_BITS'(HOT_DEPTH)
      && cold_stat.count <= CNT_BITS'(COLD_DEPTH)), "queue count above depth when idle")
   `ASSERT_CLK_ALL(a_reset_quiet, reset |=> (!busy && !rsp_valid), "activity after reset")

endmodule
